// ----- hw/rtl/sce_pkg.sv -----
// Package for the sigmoid cross-entropy loss block: widths, command and status
// types, and the softplus table builder. No dependencies.
`default_nettype none

package sce_pkg;

    localparam int LOGIT_W   = 24;
    localparam int TARGET_W  = 2;
    localparam int ELOSS_W   = 24;
    localparam int SUM_W     = 36;
    localparam int CNT_W     = 13;
    localparam int SCALE_W   = 24;
    localparam int ILOSS_W   = 48;
    localparam int NUM_W     = 37;
    localparam int REM_W     = 14;
    localparam int QLO_W     = 19;
    localparam int QHI_W     = NUM_W - QLO_W;
    localparam int PLO_W     = QLO_W + SCALE_W;
    localparam int PHI_W     = QHI_W + SCALE_W;
    localparam int PROD_W    = PHI_W + QLO_W + 1;
    localparam int MAG_W     = PROD_W - 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 88;
    localparam int SP_MAX_DEPTH = 4096;
    localparam int SP_W      = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Configuration register indexes.
    localparam logic REG_NORMALIZE = 1'b0;
    localparam logic REG_SCALE     = 1'b1;

    typedef logic [SP_W-1:0] sp_table_t [0:SP_MAX_DEPTH-1];

    typedef struct packed {
        logic accept;
        logic div_step;
        logic mul_lo;
        logic mul_hi;
        logic load_fin;
    } sce_cmd_t;

    typedef struct packed {
        logic div_needed;
    } sce_status_t;

    // Unsigned long division by shift and subtract, used only while the
    // softplus table is built at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo, rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(1 + exp(-16*i/depth)) in Q16, built from a Q30 integer series.
    function automatic sp_table_t sp_build(input int depth_log2);
        logic [63:0] h, t, pos, neg, step, e, z, z2, p, s;
        sp_table_t tab;
        tab = '{default: '0};
        h = (64'd16 << 30) >> depth_log2;
        t = 64'd1 << 30;
        pos = 64'd1 << 30;
        neg = '0;
        for (int k = 1; k <= 24; k++)
        begin
            t = udiv64((t * h) >> 30, 64'(k));
            if ((k & 1) == 1) neg = neg + t;
            else pos = pos + t;
        end
        step = pos - neg;
        e = 64'd1 << 30;
        for (int i = 0; i < (1 << depth_log2); i++)
        begin
            z = udiv64(e << 30, (64'd2 << 30) + e);
            z2 = (z * z) >> 30;
            p = z;
            s = '0;
            for (int k = 0; k < 16; k++)
            begin
                s = s + udiv64(p, 64'(2 * k + 1));
                p = (p * z2) >> 30;
            end
            tab[i] = SP_W'((2 * s + 64'd8192) >> 14);
            e = (e * step + (64'd1 << 29)) >> 30;
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sce_ctrl.sv -----
// Controller for the sigmoid cross-entropy loss block: handshakes and the
// sequence of divide and multiply steps at the end of an instance. Uses sce_pkg.
`default_nettype none

module sce_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tlast,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire sce_pkg::sce_status_t status,
    output sce_pkg::sce_cmd_t         cmd
);
    import sce_pkg::*;

    localparam logic [2:0] S_RUN    = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_MUL_LO = 3'd2;
    localparam logic [2:0] S_MUL_HI = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [5:0] DIV_LAST = 6'(NUM_W - 1);

    logic [2:0] state_reg, state_next;
    logic [5:0] div_cnt_reg, div_cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_RUN) && out_free;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd = '0;
        cmd.accept = s_tvalid && s_tready;
        case (state_reg)
            S_RUN:
            begin
                if (cmd.accept && s_tlast)
                begin
                    div_cnt_next = '0;
                    state_next = status.div_needed ? S_DIV : S_MUL_LO;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == DIV_LAST)
                    state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_fin = 1'b1;
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
        out_valid_next = out_valid_reg && !m_tready;
        if ((cmd.accept && !s_tlast) || cmd.load_fin)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            div_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            div_cnt_reg <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_ready_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == S_RUN)
        else $error("input ready outside the run state");
    a_last_leaves_run: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> state_reg != S_RUN)
        else $error("last transfer did not start instance finish");
    a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_cnt_reg <= DIV_LAST)
        else $error("divide step count overrun");
    a_fin_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_fin |=> m_tvalid && state_reg == S_RUN)
        else $error("instance result not presented");

endmodule

`default_nettype wire

// ----- hw/rtl/sce_datapath.sv -----
// Datapath for the sigmoid cross-entropy loss block: element loss, accumulators,
// restoring divider, split multiplier and output register. Uses sce_pkg.
`default_nettype none

module sce_datapath #(
    parameter int SOFTPLUS_TABLE_DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic                     wr_index,
    input  wire logic [sce_pkg::SCALE_W-1:0] wr_data,
    input  wire logic [sce_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                     s_tlast,
    input  wire sce_pkg::sce_cmd_t        cmd,
    output sce_pkg::sce_status_t          status,
    output logic [sce_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import sce_pkg::*;

    localparam int IDXW = $clog2(SOFTPLUS_TABLE_DEPTH);
    localparam sp_table_t SP_TAB = sp_build(IDXW);

    logic                 normalize_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [LOGIT_W-1:0]   logit;
    logic [TARGET_W-1:0]  target;
    logic                 x_neg, counted;
    logic [LOGIT_W-1:0]   a;
    logic [IDXW-1:0]      idx;
    logic [SP_W-1:0]      sp;
    logic [ELOSS_W-1:0]   eloss;
    logic [SUM_W:0]       sum_wide;

    logic [ELOSS_W-1:0]   hold_eloss_reg;
    logic                 hold_counted_reg;
    logic [CNT_W-1:0]     fin_cnt_reg;
    logic [NUM_W-1:0]     q_reg;
    logic [REM_W-1:0]     rem_reg;
    logic                 scale_neg_reg;
    logic [SCALE_W-1:0]   scale_mag_reg;
    logic [PLO_W-1:0]     plo_reg;
    logic [PHI_W-1:0]     phi_reg;

    logic [REM_W-1:0]     rem_shift;
    logic [REM_W:0]       rem_diff;
    logic [PROD_W-1:0]    prod;
    logic [MAG_W-1:0]     mag;
    logic [ILOSS_W-1:0]   iloss;

    logic [ELOSS_W-1:0]   out_eloss_reg;
    logic                 out_counted_reg;
    logic [ILOSS_W-1:0]   out_iloss_reg;
    logic [CNT_W-1:0]     out_icnt_reg;
    logic                 out_done_reg;

    assign logit = s_tdata[LOGIT_W-1:0];
    assign target = s_tdata[LOGIT_W+TARGET_W-1:LOGIT_W];
    assign x_neg = logit[LOGIT_W-1];
    assign a = x_neg ? (LOGIT_W'(0) - logit) : logit;
    assign counted = !target[1];
    assign idx = a[19 -: IDXW];
    assign sp = (a[LOGIT_W-1:20] != '0) ? '0 : SP_TAB[12'(idx)];

    always_comb
    begin
        eloss = '0;
        if (counted)
            eloss = ((x_neg == target[0]) ? a : '0) + ELOSS_W'(sp);
        sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(eloss);
        sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        cnt_next = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CNT_W'(1);
        if (!counted)
        begin
            sum_next = sum_reg;
            cnt_next = cnt_reg;
        end
    end

    assign status.div_needed = normalize_reg && (cnt_next != '0);

    // One quotient bit per step.
    assign rem_shift = {rem_reg[REM_W-2:0], q_reg[NUM_W-1]};
    assign rem_diff = {1'b0, rem_shift} - {2'b0, fin_cnt_reg};

    assign prod = {phi_reg, {QLO_W{1'b0}}} + PROD_W'(plo_reg);
    assign mag = MAG_W'((prod + PROD_W'(32768)) >> 16);
    assign iloss = scale_neg_reg ? (ILOSS_W'(0) - ILOSS_W'(mag)) : ILOSS_W'(mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normalize_reg <= 1'b0;
            scale_reg <= SCALE_W'(65536);
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en && wr_index == REG_NORMALIZE)
                normalize_reg <= wr_data[0];
            if (wr_en && wr_index == REG_SCALE)
                scale_reg <= wr_data;
            if (cmd.accept)
            begin
                sum_reg <= s_tlast ? '0 : sum_next;
                cnt_reg <= s_tlast ? '0 : cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && s_tlast)
        begin
            hold_eloss_reg <= eloss;
            hold_counted_reg <= counted;
            fin_cnt_reg <= cnt_next;
            rem_reg <= '0;
            q_reg <= status.div_needed
                ? (NUM_W'(sum_next) + NUM_W'(cnt_next >> 1)) : NUM_W'(sum_next);
            scale_neg_reg <= scale_reg[SCALE_W-1];
            scale_mag_reg <= scale_reg[SCALE_W-1] ? (SCALE_W'(0) - scale_reg) : scale_reg;
        end
        if (cmd.div_step)
        begin
            if (!rem_diff[REM_W])
            begin
                rem_reg <= rem_diff[REM_W-1:0];
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.mul_lo)
            plo_reg <= PLO_W'(q_reg[QLO_W-1:0]) * PLO_W'(scale_mag_reg);
        if (cmd.mul_hi)
            phi_reg <= PHI_W'(q_reg[NUM_W-1:QLO_W]) * PHI_W'(scale_mag_reg);
        if (cmd.accept && !s_tlast)
        begin
            out_eloss_reg <= eloss;
            out_counted_reg <= counted;
            out_iloss_reg <= '0;
            out_icnt_reg <= '0;
            out_done_reg <= 1'b0;
        end
        if (cmd.load_fin)
        begin
            out_eloss_reg <= hold_eloss_reg;
            out_counted_reg <= hold_counted_reg;
            out_iloss_reg <= iloss;
            out_icnt_reg <= fin_cnt_reg;
            out_done_reg <= 1'b1;
        end
    end

    assign m_tdata = {2'b0, out_icnt_reg, out_iloss_reg, out_counted_reg, out_eloss_reg};
    assign m_tlast = out_done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sigmoid_cross_entropy_loss.sv -----
// Top level of the sigmoid cross-entropy loss block: joins controller and
// datapath. Depends on sce_pkg, sce_ctrl and sce_datapath.
`default_nettype none

// Usage:
// Items arrive on the s_ group: tdata carries the Q7.16 logit and the 2-bit
// label, tlast marks the final element of an instance. Each accepted transfer
// yields exactly one result transfer on the m_ group, carrying the element
// loss and its counted flag; on the instance's last element the same result
// also carries the instance loss and count, and m_tlast is high.
// Ordinary elements: a new transfer is accepted every cycle as long as the
// output register is empty or being drained. The result is registered and
// appears in the cycle after acceptance. A last element runs the instance
// finish: one-bit restoring division of the 37-bit numerator when normalize
// is set and the count is nonzero, then the two halves of the split 37x24
// scale multiply, then the output load; the input is held off until the
// finish is done. If the receiver stalls, the result waits in the output
// register and input acceptance pauses until it is taken. Reset clears the
// accumulators, normalize (off) and scale (1.0); the softplus table is
// constant logic and needs no fill. The user must write registers through
// wr_en, wr_index and wr_data only while idle; the block does not enforce it.
module sigmoid_cross_entropy_loss #(
    parameter int SOFTPLUS_TABLE_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic        wr_index,
    input  wire logic [23:0] wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // logit [23:0], target [25:24], zero [31:26]
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // element_loss [23:0], element_counted [24], instance_loss [72:25],
    // instance_count [85:73], zero [87:86]
    output logic [87:0]      m_tdata,
    output logic             m_tlast
);
    import sce_pkg::*;

    sce_cmd_t    cmd;
    sce_status_t status;

    sce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sce_datapath #(
        .SOFTPLUS_TABLE_DEPTH (SOFTPLUS_TABLE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the sigmoid cross-entropy loss block.
// Depends on sce_pkg and the sigmoid_cross_entropy_loss top level.
`timescale 1ns / 1ps

// The scoreboard models the block: it keeps its own softplus table, the
// running loss and count of the open instance and the two registers, and
// queues one predicted result for every input transfer.
class loss_scoreboard;
    typedef struct {
        logic [23:0] eloss;
        logic        counted;
        logic [47:0] iloss;
        logic [12:0] icount;
        logic        done;
    } loss_result_t;

    loss_result_t    pending_results[$];
    int unsigned     softplus_q16[256];
    longint unsigned acc_loss;
    int unsigned     acc_count;
    bit              norm_on;
    logic [23:0]     scale;
    int              errors;

    function new();
        longint unsigned h, t, pos, neg, step, e, z, z2, p, s;
        h = (64'd16 << 30) / 256;
        t = 64'd1 << 30;
        pos = 64'd1 << 30;
        neg = 0;
        for (int k = 1; k <= 24; k++)
        begin
            t = ((t * h) >> 30) / k;
            if (k % 2) neg += t;
            else pos += t;
        end
        step = pos - neg;
        e = 64'd1 << 30;
        for (int i = 0; i < 256; i++)
        begin
            z = (e << 30) / ((64'd2 << 30) + e);
            z2 = (z * z) >> 30;
            p = z;
            s = 0;
            for (int k = 0; k < 16; k++)
            begin
                s += p / (2 * k + 1);
                p = (p * z2) >> 30;
            end
            softplus_q16[i] = 32'((2 * s + 64'd8192) >> 14);
            e = (e * step + (64'd1 << 29)) >> 30;
        end
        acc_loss = 0;
        acc_count = 0;
        norm_on = 0;
        scale = 24'd65536;
        errors = 0;
    endfunction

    function void write_reg(logic idx, logic [23:0] value);
        if (idx == sce_pkg::REG_NORMALIZE) norm_on = value[0];
        else scale = value;
    endfunction

    // Scaled and optionally normalized loss of the instance just closed.
    function logic [47:0] instance_total();
        longint unsigned q, mag, smag;
        q = acc_loss;
        if (norm_on)
        begin
            // A zero count uses the epsilon floor; the sum is then zero too.
            if (acc_count == 0) q = acc_loss * 100000;
            else q = (acc_loss + acc_count / 2) / acc_count;
        end
        if (q > (64'd1 << 39)) q = 64'd1 << 39;
        smag = scale[23] ? (64'h1000000 - scale) : scale;
        mag = (q * smag + (64'd1 << 15)) >> 16;
        if (scale[23])
        begin
            if (mag > (64'd1 << 47)) mag = 64'd1 << 47;
            return 48'(0 - mag);
        end
        if (mag > (64'd1 << 47) - 1) mag = (64'd1 << 47) - 1;
        return 48'(mag);
    endfunction

    function void note_element(logic [23:0] x, logic [1:0] y, logic last);
        loss_result_t r;
        longint unsigned a, relu, sp;
        a = x[23] ? (64'h1000000 - x) : x;
        r.eloss = 0;
        r.counted = 0;
        r.iloss = 0;
        r.icount = 0;
        r.done = 0;
        // Labels -1 and -2 are both ignored and leave the sums alone.
        if (y < 2)
        begin
            relu = (x[23] == (y == 1)) ? a : 0;
            sp = (a >= (64'd16 << 16)) ? 0 : softplus_q16[(a * 256) >> 20];
            r.eloss = 24'(relu + sp);
            r.counted = 1;
            acc_loss += r.eloss;
            if (acc_loss > (64'd1 << 36) - 1) acc_loss = (64'd1 << 36) - 1;
            if (acc_count < 8191) acc_count++;
        end
        if (last)
        begin
            r.iloss = instance_total();
            r.icount = 13'(acc_count);
            r.done = 1;
            acc_loss = 0;
            acc_count = 0;
        end
        pending_results.push_back(r);
    endfunction

    function void check_result(logic [87:0] d, logic tl);
        loss_result_t r;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result, actual %h last %b", $time, d, tl);
            errors++;
            return;
        end
        r = pending_results.pop_front();
        if (d[23:0] !== r.eloss)
        begin
            $display("%0t: element_loss expected %h actual %h", $time, r.eloss, d[23:0]);
            errors++;
        end
        if (d[24] !== r.counted)
        begin
            $display("%0t: element_counted expected %b actual %b", $time, r.counted, d[24]);
            errors++;
        end
        if (d[72:25] !== r.iloss)
        begin
            $display("%0t: instance_loss expected %h actual %h", $time, r.iloss, d[72:25]);
            errors++;
        end
        if (d[85:73] !== r.icount)
        begin
            $display("%0t: instance_count expected %0d actual %0d", $time, r.icount,
                     d[85:73]);
            errors++;
        end
        if (tl !== r.done)
        begin
            $display("%0t: instance_done expected %b actual %b", $time, r.done, tl);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        wr_en = 0;
    logic        wr_index = 0;
    logic [23:0] wr_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [87:0] m_tdata;
    logic        m_tlast;

    loss_scoreboard sb;
    bit idle_on = 1;    // random idle bursts on both sides
    bit stall_req = 0;  // asks the receiver for one long hold-off

    sigmoid_cross_entropy_loss dut (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #4 clk = ~clk;

    // Generous limit that covers every instance finish plus stalls.
    initial
    begin
        #4ms;
        $display("FAIL sigmoid_cross_entropy_loss");
        $finish;
    end

    // Both handshakes are sampled at the rising edge, before the block's
    // registers update, so every transfer is seen exactly once.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready) sb.note_element(s_tdata[23:0], s_tdata[25:24], s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request, which
    // lets the output register fill and forces the input to stall.
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                stall_req = 0;
                hold = 300;
            end
            else if (hold == 0 && idle_on && $urandom_range(0, 3) == 0)
                hold = $urandom_range(1, 5);
            if (hold > 0)
            begin
                m_tready <= 0;
                hold--;
            end
            else
                m_tready <= 1;
        end
    end

    // Offers one element and returns at the edge where its transfer happens.
    task automatic send_element(logic [23:0] x, logic [1:0] y, logic last);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'b0, y, x};
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops offering, waits until every predicted result has arrived, then
    // leaves the block idle before returning.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] value);
        @(negedge clk);
        wr_en <= 1;
        wr_index <= idx;
        wr_data <= value;
        @(negedge clk);
        wr_en <= 0;
        sb.write_reg(idx, value);
    endtask

    function automatic logic [23:0] rand_logit();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 24'hFFFFFF));
            default: return 24'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    function automatic logic [1:0] rand_label();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 2'd0;
        if (r < 8) return 2'd1;
        if (r == 8) return 2'b11;
        return 2'b10;
    endfunction

    // Well-formed instances of random length and content.
    task automatic random_instances(int items);
        int n, len;
        n = 0;
        while (n < items)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                send_element(rand_logit(), rand_label(), i == len - 1);
            n += len;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Directed: field extremes, each label, the table edge at |x| = 16,
        // and an instance that only holds ignored elements.
        send_element(24'h7FFFFF, 2'd0, 0);
        send_element(24'h800000, 2'd1, 0);
        send_element(24'h800000, 2'd0, 0);
        send_element(24'h7FFFFF, 2'd1, 0);
        send_element(24'h000000, 2'd0, 0);
        send_element(24'h000000, 2'd1, 1);
        send_element(24'h0FFFFF, 2'd0, 0);
        send_element(24'h100000, 2'd0, 0);
        send_element(24'hF00001, 2'd1, 0);
        send_element(24'hF00000, 2'd1, 0);
        send_element(24'h000FFF, 2'b11, 0);
        send_element(24'hFFFFFF, 2'b10, 1);
        send_element(24'h010000, 2'b11, 1);
        send_element(24'h555555, 2'b10, 0);
        send_element(24'hAAAAAA, 2'd1, 1);
        drain();

        write_reg(sce_pkg::REG_NORMALIZE, 24'd1);
        send_element(24'h123456, 2'b11, 0);
        send_element(24'h654321, 2'b10, 1);
        send_element(24'hFFF000, 2'd0, 0);
        send_element(24'h000800, 2'd1, 0);
        send_element(24'h7FFFFF, 2'd0, 1);
        random_instances(120);
        drain();

        write_reg(sce_pkg::REG_NORMALIZE, 24'd0);
        write_reg(sce_pkg::REG_SCALE, 24'h800000);
        random_instances(100);
        stall_req = 1;
        random_instances(50);
        drain();

        // One long instance of maximal losses under the largest positive
        // scale drives the instance loss high.
        write_reg(sce_pkg::REG_SCALE, 24'h7FFFFF);
        for (int i = 0; i < 120; i++)
            send_element(24'h800000, 2'd1, i == 119);
        drain();

        write_reg(sce_pkg::REG_NORMALIZE, 24'd1);
        random_instances(100);
        drain();

        write_reg(sce_pkg::REG_SCALE, 24'($urandom));
        random_instances(100);
        drain();

        write_reg(sce_pkg::REG_NORMALIZE, 24'd0);
        write_reg(sce_pkg::REG_SCALE, 24'hFFFFFF);
        idle_on = 0;
        random_instances(150);
        drain();

        if (sb.errors == 0)
            $display("PASS sigmoid_cross_entropy_loss");
        else
            $display("FAIL sigmoid_cross_entropy_loss");
        $finish;
    end
endmodule
